// File: hdl/ptbp_pkg.sv
package ptbp_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);
	localparam int COLOR_W       = 8;
	localparam int PIXEL_W       = 32;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 8;
	localparam int PROD_W        = 2 * COLOR_W;

	localparam logic [COLOR_W-1:0] COLOR_MAX  = 8'hff;
	localparam logic [PIXEL_W-1:0] ALPHA_MASK = 32'hff000000;

	// input item kinds
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_PIXEL = 1'b1;

	// output packing
	localparam logic FMT_RGB888 = 1'b0;
	localparam logic FMT_RGB565 = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TONE_ENABLE = 3'd0,
		REG_BLEND_ALPHA = 3'd1,
		REG_BLEND_RED   = 3'd2,
		REG_BLEND_GREEN = 3'd3,
		REG_BLEND_BLUE  = 3'd4,
		REG_OUT_FORMAT  = 3'd5,
		REG_KEEP_ALPHA  = 3'd6
	} cfg_reg_t;

	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [PIXEL_W-1:0] pixel_t;

endpackage

// File: hdl/ptbp_in_if.sv
interface ptbp_in_if;
	logic                        valid;
	logic                        ready;
	logic                        func;
	logic [ptbp_pkg::TABLE_AW-1:0] table_index;
	logic [ptbp_pkg::COLOR_W-1:0]  table_value;
	logic [ptbp_pkg::PIXEL_W-1:0]  pixel_in;

	modport source (output valid, output func, output table_index, output table_value,
		output pixel_in, input ready);
	modport sink (input valid, input func, input table_index, input table_value,
		input pixel_in, output ready);
endinterface

// File: hdl/ptbp_out_if.sv
interface ptbp_out_if;
	logic                         valid;
	logic                         ready;
	logic [ptbp_pkg::PIXEL_W-1:0] pixel_out;

	modport source (output valid, output pixel_out, input ready);
	modport sink (input valid, input pixel_out, output ready);
endinterface

// File: hdl/ptbp_ram.sv
module ptbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/pixel_tone_blend_pack.sv
// A pixel item passes the stage-1, stage-2 and output registers to reach out_ch.
// Throughput: one item per cycle, load or pixel; stalls only on output backpressure.
// Three copies of the tone table, one per color, give three lookups per cycle.
// Reset (arst_n low, asynchronous): config registers and pipeline valids clear.
// The tone table has no reset; entries hold garbage until loaded.
module pixel_tone_blend_pack (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ptbp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ptbp_pkg::CFG_DATA_W-1:0]     cfg_data,
	ptbp_in_if.sink                             in_ch,
	ptbp_out_if.source                          out_ch
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic             tone_en_q;
	ptbp_pkg::color_t alpha_q;
	ptbp_pkg::color_t lvl_r_q;
	ptbp_pkg::color_t lvl_g_q;
	ptbp_pkg::color_t lvl_b_q;
	logic             fmt_q;
	logic             keep_alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_en_q    <= 1'b0;
			alpha_q      <= '0;
			lvl_r_q      <= '0;
			lvl_g_q      <= '0;
			lvl_b_q      <= '0;
			fmt_q        <= ptbp_pkg::FMT_RGB888;
			keep_alpha_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptbp_pkg::REG_TONE_ENABLE: tone_en_q    <= cfg_data[0];
				ptbp_pkg::REG_BLEND_ALPHA: alpha_q      <= cfg_data;
				ptbp_pkg::REG_BLEND_RED:   lvl_r_q      <= cfg_data;
				ptbp_pkg::REG_BLEND_GREEN: lvl_g_q      <= cfg_data;
				ptbp_pkg::REG_BLEND_BLUE:  lvl_b_q      <= cfg_data;
				ptbp_pkg::REG_OUT_FORMAT:  fmt_q        <= cfg_data[0];
				ptbp_pkg::REG_KEEP_ALPHA:  keep_alpha_q <= cfg_data[0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage enables: each stage moves when the one after it has room,
	// so bubbles collapse and the input keeps flowing while a result waits.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, out_v_q;
	logic en1, en2, en3;

	assign en3 = !out_v_q || out_ch.ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign in_ch.ready = en1;

	logic accept, load_item, pixel_item;
	assign accept     = in_ch.valid && en1;
	assign load_item  = accept && (in_ch.func == ptbp_pkg::FUNC_LOAD);
	assign pixel_item = accept && (in_ch.func == ptbp_pkg::FUNC_PIXEL);

	// ------------------------------------------------------------------
	// Stage 1: tone lookup. Load items write all three copies; the read
	// register of each copy is the stage-1 color.
	// ------------------------------------------------------------------
	ptbp_pkg::color_t tone_r_s1, tone_g_s1, tone_b_s1;
	ptbp_pkg::pixel_t pix_s1;

	ptbp_ram #(.WIDTH(ptbp_pkg::COLOR_W), .DEPTH(ptbp_pkg::TABLE_ENTRIES)) u_tbl_r (
		.clk   (clk),
		.we    (load_item),
		.waddr (in_ch.table_index),
		.wdata (in_ch.table_value),
		.re    (en1),
		.raddr (in_ch.pixel_in[23:16]),
		.rdata (tone_r_s1)
	);

	ptbp_ram #(.WIDTH(ptbp_pkg::COLOR_W), .DEPTH(ptbp_pkg::TABLE_ENTRIES)) u_tbl_g (
		.clk   (clk),
		.we    (load_item),
		.waddr (in_ch.table_index),
		.wdata (in_ch.table_value),
		.re    (en1),
		.raddr (in_ch.pixel_in[15:8]),
		.rdata (tone_g_s1)
	);

	ptbp_ram #(.WIDTH(ptbp_pkg::COLOR_W), .DEPTH(ptbp_pkg::TABLE_ENTRIES)) u_tbl_b (
		.clk   (clk),
		.we    (load_item),
		.waddr (in_ch.table_index),
		.wdata (in_ch.table_value),
		.re    (en1),
		.raddr (in_ch.pixel_in[7:0]),
		.rdata (tone_b_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= pixel_item;  // load items leave no result behind
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			pix_s1 <= in_ch.pixel_in;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: blend numerator t*(255-a) + c*a, at most 255*255.
	// ------------------------------------------------------------------
	logic [ptbp_pkg::COLOR_W-1:0] inv_alpha;
	logic [ptbp_pkg::PROD_W-1:0]  num_r, num_g, num_b;
	logic [ptbp_pkg::PROD_W-1:0]  num_r_s2, num_g_s2, num_b_s2;
	ptbp_pkg::pixel_t             pix_s2;

	assign inv_alpha = ptbp_pkg::COLOR_MAX - alpha_q;

	function automatic logic [ptbp_pkg::PROD_W-1:0] blend_num(
		input logic [ptbp_pkg::COLOR_W-1:0] t,
		input logic [ptbp_pkg::COLOR_W-1:0] ia,
		input logic [ptbp_pkg::COLOR_W-1:0] c,
		input logic [ptbp_pkg::COLOR_W-1:0] a
	);
		logic [ptbp_pkg::PROD_W-1:0] p0, p1;
		p0 = {{ptbp_pkg::COLOR_W{1'b0}}, t} * {{ptbp_pkg::COLOR_W{1'b0}}, ia};
		p1 = {{ptbp_pkg::COLOR_W{1'b0}}, c} * {{ptbp_pkg::COLOR_W{1'b0}}, a};
		return p0 + p1;
	endfunction

	assign num_r = blend_num(tone_r_s1, inv_alpha, lvl_r_q, alpha_q);
	assign num_g = blend_num(tone_g_s1, inv_alpha, lvl_g_q, alpha_q);
	assign num_b = blend_num(tone_b_s1, inv_alpha, lvl_b_q, alpha_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			num_r_s2 <= num_r;
			num_g_s2 <= num_g;
			num_b_s2 <= num_b;
			pix_s2   <= pix_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: divide by 255 (or take the source colors when tone is off) and pack.
	// x/255 == (x + 1 + (x >> 8)) >> 8, exact for x up to 255*255, the stage-2 maximum.
	// ------------------------------------------------------------------
	function automatic logic [ptbp_pkg::COLOR_W-1:0] div255(
		input logic [ptbp_pkg::PROD_W-1:0] x
	);
		logic [ptbp_pkg::PROD_W:0] s;
		s = {1'b0, x} + {{ptbp_pkg::PROD_W{1'b0}}, 1'b1}
			+ {{(ptbp_pkg::COLOR_W + 1){1'b0}}, x[ptbp_pkg::PROD_W-1:ptbp_pkg::COLOR_W]};
		return s[ptbp_pkg::PROD_W-1:ptbp_pkg::COLOR_W];
	endfunction

	ptbp_pkg::color_t r, g, b;
	ptbp_pkg::pixel_t packed_pix;
	ptbp_pkg::pixel_t pixel_q;

	always_comb begin
		if (tone_en_q) begin
			r = div255(num_r_s2);
			g = div255(num_g_s2);
			b = div255(num_b_s2);
		end else begin
			r = pix_s2[23:16];
			g = pix_s2[15:8];
			b = pix_s2[7:0];
		end

		if (fmt_q == ptbp_pkg::FMT_RGB565) begin
			// alpha never reaches the 16-bit form; upper half stays zero
			packed_pix = {16'd0, r[7:3], g[7:2], b[7:3]};
		end else if (!tone_en_q) begin
			// plain 32-bit pass-through keeps the whole source word
			packed_pix = pix_s2;
		end else begin
			packed_pix = {8'd0, r, g, b};
			if (keep_alpha_q) begin
				packed_pix = packed_pix | (pix_s2 & ptbp_pkg::ALPHA_MASK);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en3) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			pixel_q <= packed_pix;
		end
	end

	assign out_ch.valid     = out_v_q;
	assign out_ch.pixel_out = pixel_q;

endmodule
